>>> hw/rtl/upsq_pkg.sv
// ----------------------------------------------------------------------------
// upsq_pkg: shared types and constants of the urgent priority send queue
// Field widths, operation and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package upsq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_HANDLE_BITS = 16;

	localparam int PRIO_W   = 4;
	localparam int HANDLE_W = 16;	// port width of msg_handle / out_handle
	localparam int FILL_W   = 5;

	typedef enum logic {
		FUNC_PUSH = 1'b0,
		FUNC_POP  = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_FULL   = 2'd1,
		ST_POPPED = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// control from the sequencer to one cell
	typedef struct packed {
		logic occupied;		// cell index below the fill count
		logic load_push;	// take the incoming beat's entry
		logic load_next;	// take the entry of the next younger cell
	} cell_ctl_t;

endpackage

>>> hw/rtl/upsq_cell.sv
// ----------------------------------------------------------------------------
// upsq_cell: one slot of the queue row
// Holds one entry and passes a registered best-candidate token to the next
// cell every cycle; shifts toward the head when an older entry is removed.
// ----------------------------------------------------------------------------
module upsq_cell #(
	parameter int HANDLE_BITS = 16,
	parameter int IDX_W = 4,
	parameter logic [IDX_W-1:0] CELL_IDX = '0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  upsq_pkg::cell_ctl_t       ctl,
	input  logic [HANDLE_BITS-1:0]    push_handle,
	input  logic [upsq_pkg::PRIO_W-1:0] push_prio,
	input  logic                      push_urgent,
	input  logic [HANDLE_BITS-1:0]    nxt_handle,
	input  logic [upsq_pkg::PRIO_W-1:0] nxt_prio,
	input  logic                      nxt_urgent,
	input  logic                      cin_valid,
	input  logic                      cin_urgent,
	input  logic [upsq_pkg::PRIO_W-1:0] cin_prio,
	input  logic [IDX_W-1:0]          cin_idx,
	input  logic [HANDLE_BITS-1:0]    cin_handle,
	output logic [HANDLE_BITS-1:0]    ent_handle,
	output logic [upsq_pkg::PRIO_W-1:0] ent_prio,
	output logic                      ent_urgent,
	output logic                      cout_valid,
	output logic                      cout_urgent,
	output logic [upsq_pkg::PRIO_W-1:0] cout_prio,
	output logic [IDX_W-1:0]          cout_idx,
	output logic [HANDLE_BITS-1:0]    cout_handle
);
	import upsq_pkg::*;

	logic [HANDLE_BITS-1:0] handle_q;
	logic [PRIO_W-1:0]      prio_q;
	logic                   urgent_q;
	logic                   cval_q;
	logic                   curg_q;
	logic [PRIO_W-1:0]      cprio_q;
	logic [IDX_W-1:0]       cidx_q;
	logic [HANDLE_BITS-1:0] chandle_q;
	logic                   beats;
	logic                   take;

	// strictly better only, so on a tie the older (upstream) entry stays
	assign beats = (urgent_q != cin_urgent) ? urgent_q : (prio_q < cin_prio);
	assign take  = ctl.occupied && (!cin_valid || beats);

	always_ff @(posedge clk) begin
		if (ctl.load_push) begin
			handle_q <= push_handle;
			prio_q   <= push_prio;
			urgent_q <= push_urgent;
		end else if (ctl.load_next) begin
			handle_q <= nxt_handle;
			prio_q   <= nxt_prio;
			urgent_q <= nxt_urgent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cval_q <= 1'b0;
		end else begin
			cval_q <= cin_valid || take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			curg_q    <= urgent_q;
			cprio_q   <= prio_q;
			cidx_q    <= CELL_IDX;
			chandle_q <= handle_q;
		end else begin
			curg_q    <= cin_urgent;
			cprio_q   <= cin_prio;
			cidx_q    <= cin_idx;
			chandle_q <= cin_handle;
		end
	end

	assign ent_handle  = handle_q;
	assign ent_prio    = prio_q;
	assign ent_urgent  = urgent_q;
	assign cout_valid  = cval_q;
	assign cout_urgent = curg_q;
	assign cout_prio   = cprio_q;
	assign cout_idx    = cidx_q;
	assign cout_handle = chandle_q;

endmodule

>>> hw/rtl/urgent_priority_send_queue.sv
// ----------------------------------------------------------------------------
// urgent_priority_send_queue: transmit queue of message handles
// Push appends in arrival order; pop removes the best entry (urgent first,
// then lowest priority number, then oldest) and the rest close up.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: func selects
//   push or pop, msg_handle/prio_level/is_urgent give the entry on push.
//   Output channel (out_valid/out_ready) returns exactly one result beat per
//   command: status_code, the popped entry (zero unless popped) and the
//   fill count after the operation.
//   A push or a pop on an empty queue goes from acceptance straight to the
//   response state; a pop that finds entries first passes the scan state,
//   whose length is set by the search token that walks the cell row one cell
//   per clock, and then the remove state before the response state.
//   One command is in work at a time; the next is taken as soon as the
//   previous result sits in the output register, even if not yet taken.
//   A stalled receiver holds the result in the output register; a following
//   command then waits in its finished state until the register frees.
//   Reset empties the queue (fill count zero) and drops any pending beat;
//   entry contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module urgent_priority_send_queue #(
	parameter int QUEUE_DEPTH = upsq_pkg::DEF_QUEUE_DEPTH,
	parameter int HANDLE_BITS = upsq_pkg::DEF_HANDLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [upsq_pkg::HANDLE_W-1:0] msg_handle,
	input  logic [upsq_pkg::PRIO_W-1:0]   prio_level,
	input  logic                          is_urgent,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    status_code,
	output logic [upsq_pkg::HANDLE_W-1:0] out_handle,
	output logic [upsq_pkg::PRIO_W-1:0]   out_prio,
	output logic                          out_urgent,
	output logic [upsq_pkg::FILL_W-1:0]   fill_count
);
	import upsq_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_REMOVE,
		S_RESP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   scan_q;
	logic [IDX_W-1:0]   best_q;

	// pending result, waiting for the output register
	status_t            res_status_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic [PRIO_W-1:0]  res_prio_q;
	logic               res_urgent_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [PRIO_W-1:0]  out_prio_q;
	logic               out_urgent_q;
	logic [FILL_W-1:0]  out_fill_q;

	logic               in_fire;
	logic               out_free;
	logic               out_load;
	logic [HANDLE_BITS-1:0] push_handle;
	logic [HANDLE_BITS+HANDLE_W-1:0] in_handle_ext;
	logic [HANDLE_BITS+HANDLE_W-1:0] res_handle_ext;
	logic [CNT_W+FILL_W-1:0] count_ext;

	// cell row wiring; slot QUEUE_DEPTH of the candidate chain is the row output
	logic [HANDLE_BITS-1:0] ent_handle [QUEUE_DEPTH];
	logic [PRIO_W-1:0]      ent_prio   [QUEUE_DEPTH];
	logic                   ent_urgent [QUEUE_DEPTH];
	logic                   c_valid  [QUEUE_DEPTH+1];
	logic                   c_urgent [QUEUE_DEPTH+1];
	logic [PRIO_W-1:0]      c_prio   [QUEUE_DEPTH+1];
	logic [IDX_W-1:0]       c_idx    [QUEUE_DEPTH+1];
	logic [HANDLE_BITS-1:0] c_handle [QUEUE_DEPTH+1];

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (state_q == S_RESP) && out_free;

	assign in_handle_ext = {{HANDLE_BITS{1'b0}}, msg_handle};
	assign push_handle   = in_handle_ext[HANDLE_BITS-1:0];

	// token enters the head of the row empty
	assign c_valid[0]  = 1'b0;
	assign c_urgent[0] = 1'b0;
	assign c_prio[0]   = '0;
	assign c_idx[0]    = '0;
	assign c_handle[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam logic [IDX_W-1:0] CIDX = IDX_W'(i);
		cell_ctl_t ctl;
		logic [HANDLE_BITS-1:0] nh;
		logic [PRIO_W-1:0]      np;
		logic                   nu;

		assign ctl.occupied  = (CNT_W'(i) < count_q);
		assign ctl.load_push = in_fire && (func == FUNC_PUSH) && (count_q == CNT_W'(i));
		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign ctl.load_next = (state_q == S_REMOVE) && (CIDX >= best_q);
			assign nh = ent_handle[i+1];
			assign np = ent_prio[i+1];
			assign nu = ent_urgent[i+1];
		end else begin : g_tail
			// youngest slot: nothing behind it to shift in
			assign ctl.load_next = 1'b0;
			assign nh = push_handle;
			assign np = prio_level;
			assign nu = is_urgent;
		end

		upsq_cell #(
			.HANDLE_BITS(HANDLE_BITS),
			.IDX_W(IDX_W),
			.CELL_IDX(CIDX)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.push_handle(push_handle),
			.push_prio(prio_level),
			.push_urgent(is_urgent),
			.nxt_handle(nh),
			.nxt_prio(np),
			.nxt_urgent(nu),
			.cin_valid(c_valid[i]),
			.cin_urgent(c_urgent[i]),
			.cin_prio(c_prio[i]),
			.cin_idx(c_idx[i]),
			.cin_handle(c_handle[i]),
			.ent_handle(ent_handle[i]),
			.ent_prio(ent_prio[i]),
			.ent_urgent(ent_urgent[i]),
			.cout_valid(c_valid[i+1]),
			.cout_urgent(c_urgent[i+1]),
			.cout_prio(c_prio[i+1]),
			.cout_idx(c_idx[i+1]),
			.cout_handle(c_handle[i+1])
		);
	end

	assign res_handle_ext = {{HANDLE_W{1'b0}}, res_handle_q};
	assign count_ext      = {{FILL_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_q       <= '0;
			best_q       <= '0;
			res_status_q <= ST_PUSHED;
			res_handle_q <= '0;
			res_prio_q   <= '0;
			res_urgent_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_handle_q <= '0;
			out_prio_q   <= '0;
			out_urgent_q <= 1'b0;
			out_fill_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_handle_q <= '0;
						res_prio_q   <= '0;
						res_urgent_q <= 1'b0;
						scan_q       <= '0;
						if (func == FUNC_PUSH) begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_PUSHED;
								count_q      <= count_q + CNT_W'(1);
							end
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// scan_q counts the token's way across the whole row
					scan_q <= scan_q + IDX_W'(1);
					if (scan_q == IDX_W'(QUEUE_DEPTH - 1)) begin
						best_q       <= c_idx[QUEUE_DEPTH];
						res_status_q <= ST_POPPED;
						res_handle_q <= c_handle[QUEUE_DEPTH];
						res_prio_q   <= c_prio[QUEUE_DEPTH];
						res_urgent_q <= c_urgent[QUEUE_DEPTH];
						state_q      <= S_REMOVE;
					end
				end
				S_REMOVE: begin
					// cells at and behind the winner shift one toward the head
					count_q <= count_q - CNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_handle_q <= res_handle_ext[HANDLE_W-1:0];
						out_prio_q   <= res_prio_q;
						out_urgent_q <= res_urgent_q;
						out_fill_q   <= count_ext[FILL_W-1:0];
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status_code = out_status_q;
	assign out_handle  = out_handle_q;
	assign out_prio    = out_prio_q;
	assign out_urgent  = out_urgent_q;
	assign fill_count  = out_fill_q;

endmodule

>>> verif/urgent_priority_send_queue_test.sv
// ----------------------------------------------------------------------------
// urgent_priority_send_queue_test: self-checking bench for the send queue
// Drives push and pop commands over the valid/ready input channel and checks
// every result beat against an in-bench model of the queue: arrival order,
// urgent-first selection, lowest priority number next, oldest on ties, with
// full and empty reporting. A short directed table comes first, then
// random traffic whose push/pop mix drifts so the queue swings between
// empty and full. Both channels idle at random. The receiver also holds off
// once for a long stretch, and the sender drains the queue now and then.
// ----------------------------------------------------------------------------
module urgent_priority_send_queue_test;
	import upsq_pkg::*;

	localparam int DEPTH = DEF_QUEUE_DEPTH;
	localparam int HBITS = DEF_HANDLE_BITS;
	localparam logic [63:0] HANDLE_MASK = (64'd1 << HBITS) - 64'd1;

	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 20;
	localparam int IDLE_PCT = 18;
	localparam int LONG_HOLD_CYCLES = 250;

	// one command beat as offered on the input channel
	typedef struct {
		func_t             op;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
		logic                urgent;
	} command_t;

	// one stored queue entry
	typedef struct {
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
		logic                urgent;
	} entry_t;

	// one result beat
	typedef struct {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
		logic                urgent;
		logic [FILL_W-1:0]   fill;
	} outcome_t;

	// directed row: expected beat typed in only where it is obvious
	typedef struct {
		command_t cmd;
		bit       typed;
		outcome_t want;
	} directed_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic [HANDLE_W-1:0] msg_handle;
	logic [PRIO_W-1:0]   prio_level;
	logic                is_urgent;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status_code;
	logic [HANDLE_W-1:0] out_handle;
	logic [PRIO_W-1:0]   out_prio;
	logic                out_urgent;
	logic [FILL_W-1:0]   fill_count;

	entry_t        queued_entries[$];	// model copy of the queue, slot 0 oldest
	outcome_t      pending_outcomes[$];	// result beats still owed by the block
	directed_row_t directed_rows[$];

	int  mismatches = 0;
	int  result_beats = 0;
	bit  calm = 0;			// no idling on either side while set
	bit  hold_request = 0;		// asks the receiver for one long hold-off

	urgent_priority_send_queue #(
		.QUEUE_DEPTH(DEPTH),
		.HANDLE_BITS(HBITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.msg_handle (msg_handle),
		.prio_level (prio_level),
		.is_urgent  (is_urgent),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status_code(status_code),
		.out_handle (out_handle),
		.out_prio   (out_prio),
		.out_urgent (out_urgent),
		.fill_count (fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One line per mismatch, and a count.
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Queue model: applies one command and returns the beat it must produce.
	// Urgent beats non-urgent; within equal urgency the strictly lower
	// priority number wins, so the oldest keeps ties. Out-of-range priorities
	// (10..15) just compare numerically above 9.
	function automatic outcome_t apply_queue_command(input command_t c);
		outcome_t r;
		entry_t   e;
		int       best;
		bit       better;
		r.status = ST_PUSHED;
		r.handle = '0;
		r.prio = '0;
		r.urgent = 1'b0;
		if (c.op == FUNC_PUSH) begin
			if (queued_entries.size() >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				e.handle = c.handle & HANDLE_MASK[HANDLE_W-1:0];
				e.prio = c.prio;
				e.urgent = c.urgent;
				queued_entries.push_back(e);
				r.status = ST_PUSHED;
			end
		end else if (queued_entries.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			best = 0;
			for (int i = 1; i < queued_entries.size(); i++) begin
				if (queued_entries[i].urgent != queued_entries[best].urgent)
					better = queued_entries[i].urgent;
				else
					better = queued_entries[i].prio < queued_entries[best].prio;
				if (better) best = i;
			end
			r.handle = queued_entries[best].handle;
			r.prio = queued_entries[best].prio;
			r.urgent = queued_entries[best].urgent;
			queued_entries.delete(best);
			r.status = ST_POPPED;
		end
		r.fill = FILL_W'(queued_entries.size());
		return r;
	endfunction

	// Table row builder. Typed rows carry no popped entry, so only the
	// status and the fill count are given.
	function automatic void add_row(input func_t op, input logic [HANDLE_W-1:0] h,
			input logic [PRIO_W-1:0] p, input logic u, input bit typed,
			input status_t st, input int fill);
		directed_row_t row;
		row.cmd.op = op;
		row.cmd.handle = h;
		row.cmd.prio = p;
		row.cmd.urgent = u;
		row.typed = typed;
		row.want.status = st;
		row.want.handle = '0;
		row.want.prio = '0;
		row.want.urgent = 1'b0;
		row.want.fill = FILL_W'(fill);
		directed_rows.push_back(row);
	endfunction

	// Offers one command beat and waits for the handshake. The model runs at
	// the accepting edge; valid stays high so a following beat can go out
	// back to back.
	task automatic offer_command(input command_t c, input bit typed, input outcome_t typed_want);
		outcome_t predicted;
		in_valid <= 1'b1;
		func <= c.op;
		msg_handle <= c.handle;
		prio_level <= c.prio;
		is_urgent <= c.urgent;
		do @(posedge clk); while (!in_ready);
		predicted = apply_queue_command(c);
		pending_outcomes.push_back(typed ? typed_want : predicted);
	endtask

	// Random sender gap before the next beat.
	task automatic sender_gap();
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	// Lowers valid and waits until every owed result beat has arrived.
	task automatic drain_queue_results();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: checks each accepted beat against the oldest owed
	// outcome, and paces out_ready (random stalls, calm stretch, one long
	// hold-off counted here in cycles).
	// ------------------------------------------------------------------
	initial begin : result_side
		int       hold_left;
		outcome_t want;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				result_beats++;
				if (pending_outcomes.size() == 0) begin
					report_mismatch($sformatf("beat %0d arrived with nothing owed, status %0d",
						result_beats, status_code));
				end else begin
					want = pending_outcomes.pop_front();
					if (status_code !== want.status)
						report_mismatch($sformatf("beat %0d status %0d, want %0d",
							result_beats, status_code, want.status));
					if (out_handle !== want.handle)
						report_mismatch($sformatf("beat %0d handle %h, want %h",
							result_beats, out_handle, want.handle));
					if (out_prio !== want.prio)
						report_mismatch($sformatf("beat %0d prio %0d, want %0d",
							result_beats, out_prio, want.prio));
					if (out_urgent !== want.urgent)
						report_mismatch($sformatf("beat %0d urgent %b, want %b",
							result_beats, out_urgent, want.urgent));
					if (fill_count !== want.fill)
						report_mismatch($sformatf("beat %0d fill %0d, want %0d",
							result_beats, fill_count, want.fill));
				end
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: a hang or a lost beat ends here.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Command side: reset, directed table, random traffic, drain, verdict.
	// ------------------------------------------------------------------
	initial begin : command_side
		command_t c;
		outcome_t none;
		int       push_pct;
		int       mix_pct[10];

		mix_pct = '{80, 50, 20, 95, 50, 5, 70, 40, 90, 30};
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_PUSH;
		msg_handle = '0;
		prio_level = '0;
		is_urgent = 1'b0;
		out_ready = 1'b0;
		none = '{ST_PUSHED, '0, '0, 1'b0, '0};

		// Directed table.
		// Pop on an empty queue straight after reset.
		add_row(FUNC_POP, 16'h0000, 4'd0, 1'b0, 1, ST_EMPTY, 0);
		// Fill to the brim: handle extremes, priority 0/9, out-of-range
		// priorities, urgent ties and non-urgent ties.
		add_row(FUNC_PUSH, 16'h0000, 4'd0,  1'b0, 1, ST_PUSHED, 1);
		add_row(FUNC_PUSH, 16'hFFFF, 4'd9,  1'b0, 1, ST_PUSHED, 2);
		add_row(FUNC_PUSH, 16'h1234, 4'd15, 1'b0, 1, ST_PUSHED, 3);
		add_row(FUNC_PUSH, 16'hA5A5, 4'd5,  1'b1, 1, ST_PUSHED, 4);
		add_row(FUNC_PUSH, 16'h5A5A, 4'd5,  1'b1, 1, ST_PUSHED, 5);
		add_row(FUNC_PUSH, 16'h0001, 4'd0,  1'b0, 1, ST_PUSHED, 6);
		add_row(FUNC_PUSH, 16'h8000, 4'd10, 1'b0, 1, ST_PUSHED, 7);
		add_row(FUNC_PUSH, 16'h7FFF, 4'd3,  1'b1, 1, ST_PUSHED, 8);
		add_row(FUNC_PUSH, 16'hC3C3, 4'd9,  1'b1, 1, ST_PUSHED, 9);
		add_row(FUNC_PUSH, 16'h3C3C, 4'd8,  1'b0, 1, ST_PUSHED, 10);
		add_row(FUNC_PUSH, 16'hFFFE, 4'd15, 1'b1, 1, ST_PUSHED, 11);
		add_row(FUNC_PUSH, 16'h00FF, 4'd1,  1'b0, 1, ST_PUSHED, 12);
		add_row(FUNC_PUSH, 16'hFF00, 4'd0,  1'b1, 1, ST_PUSHED, 13);
		add_row(FUNC_PUSH, 16'h0F0F, 4'd0,  1'b1, 1, ST_PUSHED, 14);
		add_row(FUNC_PUSH, 16'hF0F0, 4'd7,  1'b0, 1, ST_PUSHED, 15);
		add_row(FUNC_PUSH, 16'h5555, 4'd2,  1'b0, 1, ST_PUSHED, 16);
		// Push on a full queue is turned away, queue untouched.
		add_row(FUNC_PUSH, 16'hAAAA, 4'd0,  1'b1, 1, ST_FULL, 16);
		// Pops: selection order is left to the model.
		repeat (6) add_row(FUNC_POP, 16'hFFFF, 4'd15, 1'b1, 0, ST_POPPED, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			sender_gap();
			offer_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
		end
		drain_queue_results();

		// Random traffic. The push share changes every 80 items so the queue
		// keeps swinging between empty and full.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			push_pct = mix_pct[(n / 80) % 10];
			if (n == 150) hold_request = 1;		// receiver goes quiet, input backs up
			if (n == 300) calm = 1;			// a stretch with no idling at all
			if (n == 450) calm = 0;
			if (n == 500) drain_queue_results();
			c.op = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
			c.handle = HANDLE_W'($urandom);
			c.prio = ($urandom_range(99) < 8) ? PRIO_W'($urandom_range(15, 10))
				: PRIO_W'($urandom_range(9, 0));
			c.urgent = ($urandom_range(99) < 25);
			sender_gap();
			offer_command(c, 0, none);
		end

		drain_queue_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
